// ----- rtl/core/cps_pkg.sv -----
`timescale 1ns / 1ps

package cps_pkg;

	localparam int CoordBits = 12;
	localparam int PosBits   = CoordBits + 1;
	localparam int SqBits    = 2 * CoordBits;
	localparam int FrameBits = 13;
	localparam int ColorBits = 32;
	localparam int AddrBits  = 3;
	localparam int DataBits  = 32;

	localparam logic [FrameBits-1:0] FrameReset = 13'd4096;

	localparam logic FuncStart = 1'b0;
	localparam logic FuncStep  = 1'b1;

	localparam logic RegFrameWidth  = 1'b0;
	localparam logic RegFrameHeight = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [CoordBits-1:0] center_x;
		logic [CoordBits-1:0] center_y;
		logic [CoordBits-1:0] radius;
		logic                 fill_mode;
		logic                 blend_flag;
		logic [ColorBits-1:0] color_in;
	} cps_item_t;

	typedef struct packed {
		logic [PosBits-1:0]   pixel_x;
		logic [PosBits-1:0]   pixel_y;
		logic                 plot;
		logic                 out_of_bounds;
		logic                 blend_out;
		logic [ColorBits-1:0] color_out;
		logic                 last;
	} cps_pixel_t;

	typedef struct packed {
		logic [PosBits-1:0]   x;
		logic [PosBits-1:0]   y;
		logic [CoordBits-1:0] dx;
		logic [CoordBits-1:0] dy;
		logic [SqBits-1:0]    r_squared;
		logic                 fill;
		logic                 clamp_oob;
		logic                 blend;
		logic [ColorBits-1:0] color;
		logic                 last;
	} cps_pos_t;

	typedef struct packed {
		logic [FrameBits-1:0] width;
		logic [FrameBits-1:0] height;
	} cps_frame_t;

endpackage

// ----- rtl/core/cps_cfg.sv -----
`timescale 1ns / 1ps

module cps_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cps_pkg::AddrBits-1:0]  paddr,
	input  logic [cps_pkg::DataBits-1:0]  pwdata,
	output logic [cps_pkg::DataBits-1:0]  prdata,
	output logic                          pready,
	output cps_pkg::cps_frame_t           frame
);

	logic [cps_pkg::FrameBits-1:0] width_q;
	logic [cps_pkg::FrameBits-1:0] height_q;
	logic                          wr_en;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[cps_pkg::AddrBits-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cps_pkg::FrameReset;
			height_q <= cps_pkg::FrameReset;
		end else if (wr_en) begin
			unique case (reg_sel)
				cps_pkg::RegFrameWidth:  width_q  <= pwdata[cps_pkg::FrameBits-1:0];
				cps_pkg::RegFrameHeight: height_q <= pwdata[cps_pkg::FrameBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cps_pkg::RegFrameWidth:  prdata = cps_pkg::DataBits'(width_q);
			cps_pkg::RegFrameHeight: prdata = cps_pkg::DataBits'(height_q);
			default:                 prdata = '0;
		endcase
	end

	assign frame.width  = width_q;
	assign frame.height = height_q;

endmodule

// ----- rtl/core/cps_scan.sv -----
`timescale 1ns / 1ps

module cps_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  cps_pkg::cps_item_t   item,
	output logic                 pos_valid,
	input  logic                 pos_stall,
	output cps_pkg::cps_pos_t    pos
);

	localparam int C = cps_pkg::CoordBits;
	localparam int P = cps_pkg::PosBits;

	logic                          active_q;
	logic [P-1:0]                  cur_x_q;
	logic [P-1:0]                  cur_y_q;
	logic [C-1:0]                  row_start_x_q;
	logic [C-1:0]                  cx_q;
	logic [C-1:0]                  cy_q;
	logic [C-1:0]                  r_q;
	logic [cps_pkg::SqBits-1:0]    r_sq_q;
	logic                          fill_q;
	logic                          blend_q;
	logic                          first_q;
	logic [cps_pkg::ColorBits-1:0] color_q;

	logic              pos_valid_s1;
	cps_pkg::cps_pos_t pos_s1;

	logic         accept;
	logic         start;
	logic         step;
	logic [C-1:0] start_row_x;
	logic [C-1:0] start_y;
	logic [P-1:0] xend;
	logic [P-1:0] yend;
	logic [P-1:0] cx_ext;
	logic [P-1:0] cy_ext;
	logic [P-1:0] dx_full;
	logic [P-1:0] dy_full;
	logic         top_clamp;
	logic         left_clamp;
	logic         last;
	logic         at_row_start;

	assign item_stall = pos_valid_s1 && pos_stall;
	assign accept     = item_valid && !item_stall;
	assign start      = accept && (item.func == cps_pkg::FuncStart);
	assign step       = accept && (item.func == cps_pkg::FuncStep) && active_q;

	assign start_row_x = (item.radius > item.center_x) ? '0 : item.center_x - item.radius;
	assign start_y     = (item.radius > item.center_y) ? '0 : item.center_y - item.radius;

	assign cx_ext = P'(cx_q);
	assign cy_ext = P'(cy_q);
	assign xend   = cx_ext + P'(r_q);
	assign yend   = cy_ext + P'(r_q);

	assign dx_full = (cur_x_q >= cx_ext) ? cur_x_q - cx_ext : cx_ext - cur_x_q;
	assign dy_full = (cur_y_q >= cy_ext) ? cur_y_q - cy_ext : cy_ext - cur_y_q;

	assign top_clamp    = r_q > cy_q;
	assign left_clamp   = r_q > cx_q;
	assign at_row_start = cur_x_q == P'(row_start_x_q);
	assign last         = (cur_x_q >= xend) && (cur_y_q >= yend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			row_start_x_q <= '0;
			cx_q          <= '0;
			cy_q          <= '0;
			r_q           <= '0;
			r_sq_q        <= '0;
			fill_q        <= 1'b0;
			blend_q       <= 1'b0;
			first_q       <= 1'b0;
			color_q       <= '0;
		end else if (start) begin
			active_q      <= 1'b1;
			cx_q          <= item.center_x;
			cy_q          <= item.center_y;
			r_q           <= item.radius;
			r_sq_q        <= cps_pkg::SqBits'(item.radius) * cps_pkg::SqBits'(item.radius);
			row_start_x_q <= start_row_x;
			cur_x_q       <= P'(start_row_x);
			cur_y_q       <= P'(start_y);
			fill_q        <= item.fill_mode;
			blend_q       <= item.blend_flag;
			first_q       <= 1'b1;
			color_q       <= item.color_in;
		end else if (step) begin
			if (cur_x_q < xend) begin
				cur_x_q <= cur_x_q + 1'b1;
			end else begin
				cur_x_q <= P'(row_start_x_q);
				cur_y_q <= cur_y_q + 1'b1;
			end
			first_q <= 1'b0;
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_valid_s1 <= 1'b0;
		end else if (step) begin
			pos_valid_s1 <= 1'b1;
		end else if (!pos_stall) begin
			pos_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pos_s1.x         <= cur_x_q;
			pos_s1.y         <= cur_y_q;
			pos_s1.dx        <= dx_full[C-1:0];
			pos_s1.dy        <= dy_full[C-1:0];
			pos_s1.r_squared <= r_sq_q;
			pos_s1.fill      <= fill_q;
			pos_s1.clamp_oob <= (first_q && top_clamp) || (at_row_start && left_clamp);
			pos_s1.blend     <= blend_q;
			pos_s1.color     <= color_q;
			pos_s1.last      <= last;
		end
	end

	assign pos_valid = pos_valid_s1;
	assign pos       = pos_s1;

	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> pos_valid_s1)
		else $error("accepted step did not produce a position");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> !active_q)
		else $error("scan still active after its final position");

	a_first_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> !first_q)
		else $error("first-position mark pending without a running scan");

endmodule

// ----- rtl/core/cps_eval.sv -----
`timescale 1ns / 1ps

module cps_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pos_valid,
	output logic                pos_stall,
	input  cps_pkg::cps_pos_t   pos,
	input  cps_pkg::cps_frame_t frame,
	output logic                pixel_valid,
	input  logic                pixel_stall,
	output cps_pkg::cps_pixel_t pixel
);

	localparam int S = cps_pkg::SqBits;

	logic                pixel_valid_q;
	cps_pkg::cps_pixel_t pixel_q;

	logic         take;
	logic [S-1:0] dx_sq;
	logic [S-1:0] dy_sq;
	logic [S:0]   d2;
	logic         in_shape;
	logic         in_frame;

	assign pos_stall = pixel_valid_q && pixel_stall;
	assign take      = pos_valid && !pos_stall;

	assign dx_sq    = S'(pos.dx) * S'(pos.dx);
	assign dy_sq    = S'(pos.dy) * S'(pos.dy);
	assign d2       = (S + 1)'(dx_sq) + (S + 1)'(dy_sq);
	assign in_shape = pos.fill ? (d2 <= (S + 1)'(pos.r_squared))
	                           : (d2 == (S + 1)'(pos.r_squared));
	assign in_frame = (32'(pos.x) < 32'(frame.width)) && (32'(pos.y) < 32'(frame.height));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (take) begin
			pixel_valid_q <= 1'b1;
		end else if (!pixel_stall) begin
			pixel_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_q.pixel_x       <= pos.x;
			pixel_q.pixel_y       <= pos.y;
			pixel_q.plot          <= in_shape && in_frame;
			pixel_q.out_of_bounds <= (in_shape && !in_frame) || pos.clamp_oob;
			pixel_q.blend_out     <= pos.blend;
			pixel_q.color_out     <= pos.color;
			pixel_q.last          <= pos.last;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> pixel_valid_q)
		else $error("position taken but no result registered");

endmodule

// ----- rtl/core/circle_pixel_scanner_unit.sv -----
`timescale 1ns / 1ps
// A step accepted by the scan stage is held as a position in the scan stage register, then
// squared, compared and held in the result register that drives the pixel outputs.
// Throughput: one transaction per cycle while item_stall is low; start transactions and
// steps while idle give no pixel. The rate is set by the scan stage register feeding the
// squaring and compare stage. Reset (arst_n low) clears the scan state and valid flags
// and sets both frame registers to 4096.

module circle_pixel_scanner_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  cps_pkg::cps_item_t            item,
	output logic                          pixel_valid,
	input  logic                          pixel_stall,
	output cps_pkg::cps_pixel_t           pixel,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cps_pkg::AddrBits-1:0]  paddr,
	input  logic [cps_pkg::DataBits-1:0]  pwdata,
	output logic [cps_pkg::DataBits-1:0]  prdata,
	output logic                          pready
);

	cps_pkg::cps_frame_t frame;
	cps_pkg::cps_pos_t   pos;
	logic                pos_valid;
	logic                pos_stall;

	cps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.frame   (frame)
	);

	cps_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pos_valid  (pos_valid),
		.pos_stall  (pos_stall),
		.pos        (pos)
	);

	cps_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.pos_valid   (pos_valid),
		.pos_stall   (pos_stall),
		.pos         (pos),
		.frame       (frame),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel)
	);

endmodule
